// File: hw/rtl/hdd_pkg.sv
// shared types, codes and constants for the hysteresis direction detector
package hdd_pkg;

  localparam int unsigned LevelW  = 8;
  localparam int unsigned KeepW   = 16;
  localparam int unsigned TicksW  = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0] MarkerByte = 8'hAB;
  localparam logic [TicksW-1:0] TickMax    = {TicksW{1'b1}};

  localparam logic [LevelW-1:0] UpperReset = 8'd150;
  localparam logic [LevelW-1:0] LowerReset = 8'd50;
  localparam logic [KeepW-1:0]  KeepReset  = 16'd1000;

  localparam logic [CfgIdxW-1:0] CFG_UPPER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOWER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEEP  = 2'd2;

  localparam logic [1:0] LV_NONE = 2'd0;
  localparam logic [1:0] LV_HIGH = 2'd1;
  localparam logic [1:0] LV_LOW  = 2'd2;

  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_HL   = 3'd1;
  localparam logic [2:0] DIR_LH   = 3'd2;
  localparam logic [2:0] DIR_POS  = 3'd3;
  localparam logic [2:0] DIR_NEG  = 3'd4;

  typedef struct packed {
    logic [LevelW-1:0] upper;
    logic [LevelW-1:0] lower;
    logic [KeepW-1:0]  keep;
  } cfg_t;

  typedef struct packed {
    logic              sample_taken;
    logic [LevelW-1:0] clamped_level;
    logic [1:0]        level_state;
    logic [2:0]        direction;
    logic              direction_event;
  } res_t;

endpackage

// File: hw/rtl/hdd_level.sv
// clamp of one sample and the three-state hysteresis level update
module hdd_level import hdd_pkg::*; (
  input  cfg_t              cfg,
  input  logic [1:0]        cur_level,
  input  logic [LevelW-1:0] sample,
  output logic [LevelW-1:0] clamped,
  output logic [1:0]        next_level
);

  always_comb begin
    if (sample > cfg.upper) begin
      clamped = cfg.upper;
    end else if (sample < cfg.lower) begin
      clamped = cfg.lower;
    end else begin
      clamped = sample;
    end
  end

  always_comb begin
    unique case (cur_level)
      LV_NONE: begin
        if (clamped >= cfg.upper) begin
          next_level = LV_HIGH;
        end else if (clamped <= cfg.lower) begin
          next_level = LV_LOW;
        end else begin
          next_level = LV_NONE;
        end
      end
      LV_HIGH: next_level = (clamped <= cfg.lower) ? LV_LOW : LV_HIGH;
      LV_LOW:  next_level = (clamped >= cfg.upper) ? LV_HIGH : LV_LOW;
      default: next_level = LV_NONE;
    endcase
  end

endmodule

// File: hw/rtl/hdd_track.sv
// level, direction and tick counter state with the direction classifier
module hdd_track import hdd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              kind,
  input  logic [LevelW-1:0] sample,
  input  cfg_t              cfg,
  output res_t              res
);

  logic [1:0]        level_r, level_nxt;
  logic [2:0]        dir_r, dir_nxt;
  logic [TicksW-1:0] ticks_r, ticks_nxt;

  logic [LevelW-1:0] clamped;
  logic [1:0]        lvl_new;
  logic [TicksW-1:0] keep_ext;
  logic [TicksW-1:0] keep_x10;
  logic [TicksW-1:0] tk_mid;
  logic [2:0]        dir_mid;
  logic              pulse;
  logic              is_sample;

  hdd_level u_level (
    .cfg        (cfg),
    .cur_level  (level_r),
    .sample     (sample),
    .clamped    (clamped),
    .next_level (lvl_new)
  );

  assign keep_ext  = {{(TicksW-KeepW){1'b0}}, cfg.keep};
  assign keep_x10  = (keep_ext << 3) + (keep_ext << 1);
  assign is_sample = !kind && (sample != MarkerByte);

  // half swing / swing completion
  always_comb begin
    dir_mid = dir_r;
    tk_mid  = ticks_r;
    pulse   = 1'b0;
    if (level_r != lvl_new) begin
      if (level_r == LV_HIGH) begin
        if (dir_r == DIR_LH) begin
          dir_mid = DIR_NEG;
          tk_mid  = '0;
          pulse   = 1'b1;
        end else if (dir_r != DIR_HL) begin
          dir_mid = DIR_HL;
          tk_mid  = '0;
        end
      end else if (level_r == LV_LOW) begin
        if (dir_r == DIR_HL) begin
          dir_mid = DIR_POS;
          tk_mid  = '0;
          pulse   = 1'b1;
        end else if (dir_r != DIR_LH) begin
          dir_mid = DIR_LH;
          tk_mid  = '0;
        end
      end
    end
  end

  always_comb begin
    level_nxt = level_r;
    dir_nxt   = dir_r;
    ticks_nxt = ticks_r;
    res.sample_taken    = 1'b0;
    res.clamped_level   = '0;
    res.direction_event = 1'b0;
    if (kind) begin
      if (ticks_r != TickMax) begin
        ticks_nxt = ticks_r + 1'b1;
      end
    end else if (is_sample) begin
      res.sample_taken  = 1'b1;
      res.clamped_level = clamped;
      level_nxt         = lvl_new;
      if (level_r == LV_NONE || lvl_new == LV_NONE) begin
        dir_nxt = DIR_NONE;
      end else begin
        dir_nxt             = dir_mid;
        ticks_nxt           = tk_mid;
        res.direction_event = pulse;
        // timeout of a half swing and fallback to none
        if (tk_mid >= keep_ext) begin
          if (dir_mid == DIR_LH) begin
            dir_nxt             = DIR_POS;
            ticks_nxt           = '0;
            res.direction_event = 1'b1;
          end else if (dir_mid == DIR_HL) begin
            dir_nxt             = DIR_NEG;
            ticks_nxt           = '0;
            res.direction_event = 1'b1;
          end else if (tk_mid >= keep_x10) begin
            dir_nxt   = DIR_NONE;
            ticks_nxt = '0;
          end
        end
      end
    end
    res.level_state = level_nxt;
    res.direction   = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LV_NONE;
      dir_r   <= DIR_NONE;
      ticks_r <= '0;
    end else if (step_en) begin
      level_r <= level_nxt;
      dir_r   <= dir_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  a_event_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.direction_event) |=> (ticks_r == '0))
    else $error("direction event without counter restart");

  a_none_level_none_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.sample_taken && res.level_state == LV_NONE) |=> (dir_r == DIR_NONE))
    else $error("direction kept while level is none");

  a_tick_keeps_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && kind) |=> (dir_r == $past(dir_r) && level_r == $past(level_r)))
    else $error("tick beat changed level or direction");

endmodule

// File: hw/rtl/hysteresis_direction_detector_unit.sv
// top level of the hysteresis direction detector: handshake, config and pipeline registers
//
// One beat in, one beat out. Each input beat (a sample byte or a one millisecond tick)
// is captured in an input register, goes through the clamp, hysteresis and direction
// logic combinationally and lands in the result register; a new beat is taken every
// cycle as long as the result side keeps up. The level, direction and saturating
// 20-bit tick counter update as the beat leaves the input register, so back-to-back
// beats see each other's effect. Configuration writes take effect on the next beat
// that is processed.
module hysteresis_direction_detector_unit import hdd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [LevelW-1:0]   in_sample_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_sample_taken,
  output logic [LevelW-1:0]   out_clamped_level,
  output logic [1:0]          out_level_state,
  output logic [2:0]          out_direction,
  output logic                out_direction_event
);

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [LevelW-1:0] s1_byte_r;
  logic              out_valid_r;
  res_t              out_r;
  res_t              res;
  logic              out_free;
  logic              s1_adv;
  logic              in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper <= UpperReset;
      cfg_r.lower <= LowerReset;
      cfg_r.keep  <= KeepReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPPER: cfg_r.upper <= cfg_data[LevelW-1:0];
        CFG_LOWER: cfg_r.lower <= cfg_data[LevelW-1:0];
        CFG_KEEP:  cfg_r.keep  <= cfg_data[KeepW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_sample_byte;
    end
  end

  hdd_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .kind    (s1_kind_r),
    .sample  (s1_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_taken    = out_r.sample_taken;
  assign out_clamped_level   = out_r.clamped_level;
  assign out_level_state     = out_r.level_state;
  assign out_direction       = out_r.direction;
  assign out_direction_event = out_r.direction_event;

  // with keep zero a completed swing falls straight back to none in the same beat
  a_event_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.direction_event) |->
      (out_r.direction == DIR_POS || out_r.direction == DIR_NEG ||
       out_r.direction == DIR_NONE))
    else $error("direction event with a half swing direction");

  a_no_sample_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.sample_taken) |->
      (out_r.clamped_level == '0 && !out_r.direction_event))
    else $error("non-sample beat carries level or event");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule
